>>> rtl/kwnrm_pkg.sv
// Shared sizes, codes and types for the k-way natural run merger.
// Used by every module under rtl/ except kwnrm_lane_ram; depends on nothing else.
package kwnrm_pkg;

	// Sizing
	localparam int LANES        = 8;
	localparam int LANE_DEPTH   = 16;
	localparam int KEY_WIDTH    = 32;

	localparam int LANE_W       = $clog2(LANES);
	localparam int LANES_P2     = 1 << LANE_W;
	localparam int PTR_W        = $clog2(LANE_DEPTH);
	localparam int CNT_W        = $clog2(LANE_DEPTH + 1);
	localparam int ADDR_W       = LANE_W + PTR_W;

	// Field widths on the stream ports
	localparam int LANE_FIELD_W = 3;
	localparam int REC_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int IN_PACK_W    = LANE_FIELD_W + REC_W;
	localparam int IN_DATA_W    = ((IN_PACK_W + 7) / 8) * 8;
	localparam int OUT_PACK_W   = STATUS_W + REC_W + LANE_FIELD_W;
	localparam int OUT_DATA_W   = ((OUT_PACK_W + 7) / 8) * 8;

	typedef enum logic [0:0] {
		CMD_PUSH = 1'b0,
		CMD_PULL = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_NONE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_OPEN,
		S_OPEN_END,
		S_ARM,
		S_SELECT,
		S_FINISH,
		S_RESP
	} fsm_t;

	// One contender in the minimum search
	typedef struct packed {
		logic                 vld;
		logic [LANE_W-1:0]    lane;
		logic [KEY_WIDTH-1:0] key;
	} cand_t;

	// Advance a lane pointer with wrap at the lane depth
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(LANE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> rtl/kwnrm_lane_ram.sv
// Single-port-write, single-port-read synchronous RAM holding all lane FIFOs.
// Read data is registered; no reset on the array.
module kwnrm_lane_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/kwnrm_min_sel.sv
// Registered minimum search over the lane head registers.
// Binary tree, lower lane wins ties; depends on kwnrm_pkg.
module kwnrm_min_sel
	import kwnrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_WIDTH-1:0] head_key [LANES],
	input  logic [LANES-1:0]     head_active,
	output cand_t                best_s1
);

	cand_t node [2*LANES_P2-1];

	// Keep a valid left child unless the right one is valid and strictly smaller
	function automatic cand_t pick(input cand_t l, input cand_t r);
		cand_t w;
		if (l.vld && (!r.vld || l.key <= r.key)) begin
			w = l;
		end else begin
			w = r;
		end
		return w;
	endfunction

	// Leaves: one per lane, padding leaves never win
	for (genvar i = 0; i < LANES_P2; i++) begin : g_leaf
		if (i < LANES) begin : g_real
			assign node[LANES_P2-1+i] = '{vld: head_active[i], lane: LANE_W'(i),
				key: head_key[i]};
		end else begin : g_pad
			assign node[LANES_P2-1+i] = '{vld: 1'b0, lane: LANE_W'(i), key: '0};
		end
	end

	// Internal nodes
	for (genvar n = 0; n < LANES_P2 - 1; n++) begin : g_node
		assign node[n] = pick(node[2*n+1], node[2*n+2]);
	end

	// Register the winner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_s1 <= '0;
		end else begin
			best_s1 <= node[0];
		end
	end

endmodule

>>> rtl/kway_natural_run_merge.sv
// Push: dispatch, then the response state loads the output register.
// Pull in an open run: dispatch, select, finish, then the response state.
// Pull that opens a run: dispatch, the lane sweep, open_end, arm, select, finish, response;
// its length is set by the lane sweep loading one head per cycle through the single RAM read port.
// One request at a time; a finished result waits in the output register.
// Reset (arst_n low, asynchronous): lanes empty, no run open, output idle.
module kway_natural_run_merge
	import kwnrm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // lane[2:0], record_key[34:3], zero pad
	input  logic                  s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // status[1:0], out_key[33:2], out_lane[36:34]
	output logic                  m_axis_tlast   // last_of_run
);

	fsm_t                    state_q, state_d;

	cmd_t                    cmd_q;
	logic [LANE_FIELD_W-1:0] lane_q;
	logic [KEY_WIDTH-1:0]    key_q;

	logic [PTR_W-1:0]        wr_ptr_q [LANES];
	logic [PTR_W-1:0]        rd_ptr_q [LANES];
	logic [CNT_W-1:0]        count_q  [LANES];
	logic [KEY_WIDTH-1:0]    head_key_q [LANES];
	logic [LANES-1:0]        head_active_q;
	logic                    run_open_q;

	logic [LANE_W-1:0]       idx_q;
	logic                    any_q;
	logic                    pend_valid_s1;
	logic [LANE_W-1:0]       pend_lane_s1;

	cand_t                   best_s1;
	cand_t                   best_q;

	status_t                 res_status_q;
	logic [REC_W-1:0]        res_key_q;
	logic [LANE_FIELD_W-1:0] res_lane_q;
	logic                    res_last_q;

	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_last_q;

	logic [LANE_W-1:0]       sel_lane;
	logic [PTR_W-1:0]        sel_rd_ptr;
	logic [PTR_W-1:0]        sel_wr_ptr;
	logic [CNT_W-1:0]        sel_count;
	logic                    lane_ok;
	logic                    push_full;
	logic                    ram_we;
	logic [KEY_WIDTH-1:0]    ram_rdata;
	logic                    take;
	logic [LANES-1:0]        act_next;
	logic                    fin_last;
	logic                    slot_free;
	logic                    open_take;

	// Lane whose pointers and count the current state works on
	always_comb begin
		unique case (state_q)
			S_DISPATCH: sel_lane = LANE_W'(lane_q);
			S_OPEN:     sel_lane = idx_q;
			S_SELECT:   sel_lane = best_s1.lane;
			default:    sel_lane = best_q.lane;
		endcase
	end

	assign sel_rd_ptr = rd_ptr_q[sel_lane];
	assign sel_wr_ptr = wr_ptr_q[sel_lane];
	assign sel_count  = count_q[sel_lane];

	assign lane_ok   = int'(lane_q) < LANES;
	assign push_full = !lane_ok || (sel_count == CNT_W'(LANE_DEPTH));
	assign ram_we    = (state_q == S_DISPATCH) && (cmd_q == CMD_PUSH) && !push_full;
	assign open_take = (state_q == S_OPEN) && (sel_count != '0);

	// Lane FIFO storage
	kwnrm_lane_ram #(
		.DATA_W (KEY_WIDTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({sel_lane, sel_wr_ptr}),
		.wdata (key_q),
		.raddr ({sel_lane, sel_rd_ptr}),
		.rdata (ram_rdata)
	);

	// Minimum over active heads
	kwnrm_min_sel u_min (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_key    (head_key_q),
		.head_active (head_active_q),
		.best_s1     (best_s1)
	);

	// Refill decision after popping the winning head
	always_comb begin
		take     = (sel_count != '0) && (ram_rdata >= best_q.key);
		act_next = head_active_q;
		act_next[best_q.lane] = take;
		fin_last = (act_next == '0);
	end

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (cmd_q == CMD_PUSH) begin
					state_d = S_RESP;
				end else if (run_open_q) begin
					state_d = S_SELECT;
				end else begin
					state_d = S_OPEN;
				end
			end
			S_OPEN: begin
				if (idx_q == LANE_W'(LANES - 1)) state_d = S_OPEN_END;
			end
			S_OPEN_END: begin
				state_d = any_q ? S_ARM : S_RESP;
			end
			S_ARM: begin
				state_d = S_SELECT;
			end
			S_SELECT: begin
				state_d = best_s1.vld ? S_FINISH : S_RESP;
			end
			S_FINISH: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lane control, run state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '{default: '0};
			rd_ptr_q      <= '{default: '0};
			count_q       <= '{default: '0};
			head_active_q <= '0;
			run_open_q    <= 1'b0;
			idx_q         <= '0;
			any_q         <= 1'b0;
			pend_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			pend_valid_s1 <= open_take;
			// Append on push
			if (ram_we) begin
				wr_ptr_q[sel_lane] <= ptr_inc(sel_wr_ptr);
				count_q[sel_lane]  <= sel_count + CNT_W'(1);
			end
			// Arm the head sweep
			if (state_q == S_DISPATCH && cmd_q == CMD_PULL && !run_open_q) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end
			// Sweep: drop each non-empty lane's front into its head
			if (state_q == S_OPEN) begin
				idx_q <= idx_q + LANE_W'(1);
				if (open_take) begin
					rd_ptr_q[sel_lane]      <= ptr_inc(sel_rd_ptr);
					count_q[sel_lane]       <= sel_count - CNT_W'(1);
					head_active_q[sel_lane] <= 1'b1;
					any_q                   <= 1'b1;
				end
			end
			if (state_q == S_OPEN_END && any_q) begin
				run_open_q <= 1'b1;
			end
			if (state_q == S_SELECT && !best_s1.vld) begin
				run_open_q <= 1'b0;
			end
			// Pop the winner, refill or retire its lane
			if (state_q == S_FINISH) begin
				head_active_q <= act_next;
				if (take) begin
					rd_ptr_q[sel_lane] <= ptr_inc(sel_rd_ptr);
					count_q[sel_lane]  <= sel_count - CNT_W'(1);
				end
				if (fin_last) run_open_q <= 1'b0;
			end
			// Output register
			if (state_q == S_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q  <= cmd_t'(s_axis_tuser);
			lane_q <= s_axis_tdata[LANE_FIELD_W-1:0];
			key_q  <= KEY_WIDTH'(s_axis_tdata[LANE_FIELD_W +: REC_W]);
		end
		pend_lane_s1 <= idx_q;
		if (pend_valid_s1) begin
			head_key_q[pend_lane_s1] <= ram_rdata;
		end else if (state_q == S_FINISH && take) begin
			head_key_q[best_q.lane] <= ram_rdata;
		end
		if (state_q == S_SELECT) begin
			best_q <= best_s1;
		end
		// Build the result
		unique case (state_q)
			S_DISPATCH: begin
				res_status_q <= push_full ? STAT_FULL : STAT_OK;
				res_key_q    <= '0;
				res_lane_q   <= '0;
				res_last_q   <= 1'b0;
			end
			S_OPEN_END, S_SELECT: begin
				res_status_q <= STAT_NONE;
				res_key_q    <= '0;
				res_lane_q   <= '0;
				res_last_q   <= 1'b0;
			end
			S_FINISH: begin
				res_status_q <= STAT_OK;
				res_key_q    <= REC_W'(best_q.key);
				res_lane_q   <= LANE_FIELD_W'(best_q.lane);
				res_last_q   <= fin_last;
			end
			default: ;
		endcase
		if (state_q == S_RESP && slot_free) begin
			out_data_q <= OUT_DATA_W'({res_lane_q, res_key_q, res_status_q});
			out_last_q <= res_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// Checks
	a_closed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_open_q && state_q == S_IDLE |-> head_active_q == '0)
		else $error("active heads with no run open");

	a_select_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SELECT && run_open_q |-> best_s1.vld)
		else $error("open run without an active head");

	a_head_fill_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_s1 |-> $past(state_q) == S_OPEN)
		else $error("head load outside the lane sweep");

	a_fail_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && res_status_q != STAT_OK |-> res_key_q == '0 && !res_last_q)
		else $error("failed request carries a key or run end");

endmodule

>>> bench/tb_kway_natural_run_merge.sv
// Self-checking bench for kway_natural_run_merge: push and pull requests over the stream ports.
// A scoreboard class predicts every response from its own lane FIFOs and head registers.
// Depends on kwnrm_pkg and the kway_natural_run_merge top level only.
module tb_kway_natural_run_merge
	import kwnrm_pkg::*;
();

	// One predicted response
	typedef struct {
		status_t                 status;
		logic [REC_W-1:0]        key;
		logic [LANE_FIELD_W-1:0] lane;
		logic                    last;
	} merge_result_t;

	// Predict responses in request order and compare them with what the block returns
	class merge_scoreboard;
		logic [REC_W-1:0] lane_queue[LANES][$];
		logic [REC_W-1:0] head_val[LANES];
		bit               head_live[LANES];
		bit               run_live;
		merge_result_t    pending_results[$];
		int               failures;

		function void note_request(input cmd_t cmd, input logic [LANE_FIELD_W-1:0] lane,
				input logic [REC_W-1:0] key);
			merge_result_t r;
			int            best;
			bit            any;
			logic [REC_W-1:0] emitted;
			r.status = STAT_OK;
			r.key    = '0;
			r.lane   = '0;
			r.last   = 1'b0;
			best     = -1;
			if (cmd == CMD_PUSH) begin
				if (int'(lane) >= LANES || lane_queue[lane].size() >= LANE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					lane_queue[lane].push_back(key);
				end
				pending_results.push_back(r);
				return;
			end
			// Open a run by loading the front of every non-empty lane
			if (!run_live) begin
				any = 1'b0;
				for (int i = 0; i < LANES; i++) begin
					if (lane_queue[i].size() > 0) begin
						head_val[i]  = lane_queue[i].pop_front();
						head_live[i] = 1'b1;
						any = 1'b1;
					end
				end
				if (!any) begin
					r.status = STAT_NONE;
					pending_results.push_back(r);
					return;
				end
				run_live = 1'b1;
			end
			// Smallest active head wins, lower lane on a tie
			for (int i = 0; i < LANES; i++) begin
				if (head_live[i] && (best < 0 || head_val[i] < head_val[best])) begin
					best = i;
				end
			end
			emitted = head_val[best];
			head_live[best] = 1'b0;
			if (lane_queue[best].size() > 0 && lane_queue[best][0] >= emitted) begin
				head_val[best]  = lane_queue[best].pop_front();
				head_live[best] = 1'b1;
			end
			r.key  = emitted;
			r.lane = LANE_FIELD_W'(best);
			r.last = 1'b1;
			for (int i = 0; i < LANES; i++) begin
				if (head_live[i]) begin
					r.last = 1'b0;
				end
			end
			if (r.last) begin
				run_live = 1'b0;
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(input logic [STATUS_W-1:0] status, input logic [REC_W-1:0] key,
				input logic [LANE_FIELD_W-1:0] lane, input logic last);
			merge_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: response with nothing outstanding: status %0d key %h lane %0d last %0d",
					$time, status, key, lane, last);
				failures++;
				return;
			end
			e = pending_results.pop_front();
			if (status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, status);
				failures++;
			end
			if (key !== e.key) begin
				$display("%0t: out_key expected %h actual %h", $time, e.key, key);
				failures++;
			end
			if (lane !== e.lane) begin
				$display("%0t: out_lane expected %0d actual %0d", $time, e.lane, lane);
				failures++;
			end
			if (last !== e.last) begin
				$display("%0t: last_of_run expected %0d actual %0d", $time, e.last, last);
				failures++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = CMD_PUSH;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	merge_scoreboard sb = new();

	kway_natural_run_merge u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one request, idling at random first, and hold it until accepted
	task automatic send_request(input cmd_t cmd, input logic [LANE_FIELD_W-1:0] lane,
			input logic [REC_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= IN_DATA_W'({key, lane});
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		sb.note_request(cmd, lane, key);
	endtask

	// Check each accepted response, then stall at random for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[36:34],
				m_axis_tlast);
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		logic [REC_W-1:0]        lane_last[LANES];
		logic [REC_W-1:0]        key;
		logic [LANE_FIELD_W-1:0] ln;
		int                      push_pct;
		int                      pick;
		for (int i = 0; i < LANES; i++) begin
			lane_last[i] = '0;
		end
		push_pct = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pull with every lane empty
		send_request(CMD_PULL, 3'd5, 32'hFFFF_FFFF);
		// Extreme keys, a tie across lanes, a tie and a descent within a lane
		send_request(CMD_PUSH, 3'd0, 32'h0000_0000);
		send_request(CMD_PUSH, 3'd7, 32'hFFFF_FFFF);
		send_request(CMD_PUSH, 3'd3, 32'd5);
		send_request(CMD_PUSH, 3'd5, 32'd5);
		send_request(CMD_PUSH, 3'd3, 32'd4);
		send_request(CMD_PUSH, 3'd0, 32'h0000_0000);
		// Open the run, then push into a lane that is still active
		send_request(CMD_PULL, 3'd2, 32'h5555_5555);
		send_request(CMD_PUSH, 3'd0, 32'd3);
		repeat (6) send_request(CMD_PULL, 3'($urandom_range(7)), $urandom());
		// Fill one lane to the brim, then push once more to see it refused
		for (int i = 0; i <= LANE_DEPTH; i++) begin
			send_request(CMD_PUSH, 3'd6, (i == 8) ? 32'd1 : 32'h8000_0000 + i);
		end

		// Random: mostly ascending runs per lane, with descents, ties and wild keys
		for (int n = 0; n < 1700; n++) begin
			case (n / 425)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			if (n % 50 == 0) begin
				case ($urandom_range(3))
					0: push_pct = 30;
					1: push_pct = 50;
					2: push_pct = 70;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(99) < push_pct) begin
				ln   = 3'($urandom_range(LANES - 1));
				pick = $urandom_range(99);
				if (pick < 65) begin
					key = lane_last[ln] + (($urandom_range(3) == 0) ? 0 : $urandom_range(1000));
				end else if (pick < 80) begin
					key = $urandom();
				end else if (pick < 92) begin
					key = lane_last[ln] - $urandom_range(1, 1000);
				end else begin
					key = lane_last[$urandom_range(LANES - 1)];
				end
				lane_last[ln] = key;
				send_request(CMD_PUSH, ln, key);
			end else begin
				send_request(CMD_PULL, 3'($urandom_range(7)), $urandom());
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then give any stray response time to show up
		while (sb.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (24) @(posedge clk);
		if (sb.failures == 0) begin
			$display("kway_natural_run_merge regression: pass");
		end else begin
			$display("kway_natural_run_merge regression: fail");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("kway_natural_run_merge regression: fail");
		$finish;
	end

endmodule
